### rtl/core/frpm_pkg.sv
// Shared types, codes and constants for the frame pacing rate meter.
// Used by the remainder unit, datapath, controller and top level.
`timescale 1ns / 1ps
`default_nettype none

package frpm_pkg;

	localparam int TICK_W    = 63;
	localparam int TIME_W    = 64;
	localparam int CNT_W     = 32;
	localparam int CFG_W     = 32;
	localparam int REM_STEPS = TICK_W;
	localparam int STEP_W    = $clog2(REM_STEPS);

	localparam logic [CFG_W-1:0]  TPS_RESET = 32'd10000000;
	localparam logic [CFG_W-1:0]  FT_RESET  = 32'd166666;
	localparam logic [TICK_W-1:0] MAX_TICK  = {TICK_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

	// Configuration register indexes
	localparam logic REG_TPS = 1'b0;
	localparam logic REG_FT  = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOGIC  = 2'd0,
		CMD_RENDER = 2'd1,
		CMD_FLAG   = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic calc_diff;
		logic calc_cmp;
		logic rem_start;
		logic commit;
	} frpm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic roll;
		logic rem_done;
	} frpm_sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

### rtl/core/frame_pacing_rate_meter_unit.sv
// Frame pacing rate meter: fixed-timestep frame limiter with per-second rate counters.
// Top level; depends on frpm_pkg, frpm_ctrl, frpm_dp (and frpm_rem below it).
//
// Usage:
//   Input channel (in_valid / in_stall) carries a command and the current tick count.
//   Each request produces exactly one result on the output channel
//   (out_valid / out_stall): go, wait_ticks and the three per-second rates.
//   Configuration (cfg_we, cfg_index, cfg_data) sets the second length and frame
//   length; write it only while no request is in flight.
// Sequencing:
//   A request steps through S_IDLE, S_DIFF, S_CMP and S_UPD; the input stays stalled
//   until its commit. When a logic or render request rolls the second over, S_DIV
//   runs the 63-step bit-serial remainder unit between S_CMP and S_UPD.
// Reset:
//   arst_n clears all reference times, counters, snapshots and the second flag
//   and restores the default second and frame lengths.
// Back-pressure:
//   A finished result waits in the output register while out_stall is high; the
//   next request may already be accepted and is held before its commit until the
//   output register is free.
`timescale 1ns / 1ps
`default_nettype none

module frame_pacing_rate_meter_unit import frpm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        cmd,
	input  wire logic [TICK_W-1:0] now_ticks,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   go,
	output logic      [TICK_W-1:0] wait_ticks,
	output logic      [CNT_W-1:0]  logic_rate,
	output logic      [CNT_W-1:0]  render_rate,
	output logic      [CNT_W-1:0]  loop_rate
);

	frpm_cmd_t ctl;
	frpm_sts_t sts;

	frpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	frpm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.now_ticks   (now_ticks),
		.go          (go),
		.wait_ticks  (wait_ticks),
		.logic_rate  (logic_rate),
		.render_rate (render_rate),
		.loop_rate   (loop_rate)
	);

	// A request just taken keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// Never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	// A new result only appears after a commit
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.commit))
		else $error("result valid without commit");

endmodule

`default_nettype wire

### rtl/core/frpm_rem.sv
// Bit-serial remainder unit: elapsed ticks modulo the second length.
// One restoring step per cycle; depends on frpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frpm_rem import frpm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TICK_W-1:0] dividend,
	input  wire logic [CFG_W-1:0]  divisor,
	output logic      [CFG_W-1:0]  rem,
	output logic                   done
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CFG_W-1:0]  rem_q;
	logic [TICK_W-1:0] dvd_q;
	logic [CFG_W:0]    trial;
	logic              fits;
	logic [CFG_W-1:0]  rem_next;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial    = {rem_q, dvd_q[TICK_W-1]};
		fits     = trial >= {1'b0, divisor};
		rem_next = fits ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(REM_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and remaining dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
		end
	end

	assign rem  = rem_q;
	assign done = !busy_q;

endmodule

`default_nettype wire

### rtl/core/frpm_dp.sv
// Datapath: configuration, reference times, counters, snapshots, result payload.
// Depends on frpm_pkg and frpm_rem; driven by frpm_ctrl through frpm_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module frpm_dp import frpm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire frpm_cmd_t         ctl,
	output frpm_sts_t              sts,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic [1:0]        cmd,
	input  wire logic [TICK_W-1:0] now_ticks,
	output logic                   go,
	output logic      [TICK_W-1:0] wait_ticks,
	output logic      [CNT_W-1:0]  logic_rate,
	output logic      [CNT_W-1:0]  render_rate,
	output logic      [CNT_W-1:0]  loop_rate
);

	logic [CFG_W-1:0]  tps_q, ft_q;
	cmd_t              cmd_q;
	logic [TICK_W-1:0] now_q;
	logic [TIME_W-1:0] df_s1, ds_s1;
	logic              roll_s2, due_s2, ovr_gt_s2;
	logic [TIME_W-1:0] ex_s2;
	logic [TICK_W-1:0] wait_s2;

	logic [TIME_W-1:0] frame_base_q, second_base_q, ovr_q;
	logic [CNT_W-1:0]  logic_cnt_q, render_cnt_q, loop_cnt_q;
	logic [CNT_W-1:0]  logic_snap_q, render_snap_q, loop_snap_q;
	logic              flag_q;
	logic              go_q;
	logic [TICK_W-1:0] wait_q;

	logic [TIME_W-1:0] ft64, tps64, now64;
	logic              is_pace, roll_c, due_c, ovr_gt_c;
	logic [TIME_W-1:0] ex_c, w_c;
	logic [TICK_W-1:0] wait_c;
	logic [CFG_W-1:0]  rem;
	logic              rem_done;
	logic [CFG_W-1:0]  rem_sel;
	logic [TIME_W:0]   ovr_sum;
	logic [TIME_W-1:0] ovr_add, ovr_sub, fb_adv, sb_roll;
	logic [CNT_W-1:0]  logic_base, render_base, loop_base;

	assign ft64  = {{(TIME_W-CFG_W){1'b0}}, ft_q};
	assign tps64 = {{(TIME_W-CFG_W){1'b0}}, tps_q};
	assign now64 = {1'b0, now_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			ft_q  <= FT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TPS: tps_q <= cfg_data;
				REG_FT:  ft_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the request, then the two elapsed times
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd_t'(cmd);
			now_q <= now_ticks;
		end
		if (ctl.calc_diff) begin
			df_s1 <= now64 - frame_base_q;
			ds_s1 <= now64 - second_base_q;
		end
	end

	// Compare stage: rollover, frame due, overrun and wait
	always_comb begin
		is_pace  = (cmd_q == CMD_LOGIC) || (cmd_q == CMD_RENDER);
		roll_c   = is_pace && !ds_s1[TIME_W-1] && (ds_s1 >= tps64);
		due_c    = !df_s1[TIME_W-1] && (df_s1 >= ft64);
		ovr_gt_c = ovr_q > ft64;
		ex_c     = df_s1 - ft64;
		w_c      = ft64 - df_s1;
		wait_c   = w_c[TIME_W-1] ? MAX_TICK : w_c[TICK_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.calc_cmp) begin
			roll_s2   <= roll_c;
			due_s2    <= due_c;
			ovr_gt_s2 <= ovr_gt_c;
			ex_s2     <= ex_c;
			wait_s2   <= wait_c;
		end
	end

	// Remainder of the elapsed second time, only needed on rollover
	frpm_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.rem_start),
		.dividend (ds_s1[TICK_W-1:0]),
		.divisor  (tps_q),
		.rem      (rem),
		.done     (rem_done)
	);

	assign sts.roll     = roll_c && (tps_q != '0);
	assign sts.rem_done = rem_done;

	// Update values
	always_comb begin
		rem_sel     = (tps_q == '0) ? '0 : rem;
		sb_roll     = now64 - {{(TIME_W-CFG_W){1'b0}}, rem_sel};
		fb_adv      = frame_base_q + ft64;
		ovr_sum     = {1'b0, ovr_q} + {1'b0, ex_s2};
		ovr_add     = ovr_sum[TIME_W] ? {TIME_W{1'b1}} : ovr_sum[TIME_W-1:0];
		ovr_sub     = ovr_q - ft64;
		logic_base  = roll_s2 ? '0 : logic_cnt_q;
		render_base = roll_s2 ? '0 : render_cnt_q;
		loop_base   = roll_s2 ? '0 : loop_cnt_q;
	end

	// Commit the request: state, snapshots and result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= '0;
			second_base_q <= '0;
			ovr_q         <= '0;
			logic_cnt_q   <= '0;
			render_cnt_q  <= '0;
			loop_cnt_q    <= '0;
			logic_snap_q  <= '0;
			render_snap_q <= '0;
			loop_snap_q   <= '0;
			flag_q        <= 1'b0;
			go_q          <= 1'b0;
			wait_q        <= '0;
		end else if (ctl.commit) begin
			go_q   <= 1'b0;
			wait_q <= '0;
			case (cmd_q)
				CMD_LOGIC: begin
					if (roll_s2) begin
						second_base_q <= sb_roll;
						flag_q        <= 1'b1;
						logic_snap_q  <= logic_cnt_q;
						loop_snap_q   <= loop_cnt_q;
					end
					loop_cnt_q <= sat_inc(loop_base);
					if (due_s2) begin
						logic_cnt_q  <= sat_inc(logic_base);
						frame_base_q <= fb_adv;
						go_q         <= 1'b1;
					end else begin
						logic_cnt_q <= logic_base;
					end
				end
				CMD_RENDER: begin
					if (roll_s2) begin
						second_base_q <= sb_roll;
						flag_q        <= 1'b1;
						logic_snap_q  <= logic_cnt_q;
						render_snap_q <= render_cnt_q;
					end
					logic_cnt_q  <= sat_inc(logic_base);
					frame_base_q <= fb_adv;
					if (ovr_gt_s2) begin
						// skip this render and pay back one period
						ovr_q        <= ovr_sub;
						render_cnt_q <= render_base;
					end else begin
						if (due_s2) begin
							ovr_q <= ovr_add;
						end else begin
							wait_q <= wait_s2;
						end
						render_cnt_q <= sat_inc(render_base);
						go_q         <= 1'b1;
					end
				end
				CMD_FLAG: begin
					go_q   <= flag_q;
					flag_q <= 1'b0;
				end
				CMD_START: begin
					frame_base_q  <= now64;
					second_base_q <= now64;
				end
				default: ;
			endcase
		end
	end

	assign go          = go_q;
	assign wait_ticks  = wait_q;
	assign logic_rate  = logic_snap_q;
	assign render_rate = render_snap_q;
	assign loop_rate   = loop_snap_q;

endmodule

`default_nettype wire

### rtl/core/frpm_ctrl.sv
// Controller state machine: sequences one request through the datapath.
// Depends on frpm_pkg; drives frpm_dp through frpm_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module frpm_ctrl import frpm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire frpm_sts_t sts,
	output frpm_cmd_t      ctl
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIFF = 5'b00010,
		S_CMP  = 5'b00100,
		S_DIV  = 5'b01000,
		S_UPD  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Datapath commands
	always_comb begin
		ctl.load_in   = (state_q == S_IDLE) && in_valid;
		ctl.calc_diff = (state_q == S_DIFF);
		ctl.calc_cmp  = (state_q == S_CMP);
		ctl.rem_start = (state_q == S_CMP) && sts.roll;
		ctl.commit    = (state_q == S_UPD) && !(out_valid_q && out_stall);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DIFF;
			S_DIFF: state_d = S_CMP;
			S_CMP:  state_d = sts.roll ? S_DIV : S_UPD;
			S_DIV:  if (sts.rem_done) state_d = S_UPD;
			S_UPD:  if (ctl.commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### bench/frame_pacing_rate_meter_unit_tb.sv
// Self-checking bench for frame_pacing_rate_meter_unit: frame due checks, render pacing,
// second rollover snapshots and flag reads under random stalls and config settings.
// Depends on frpm_pkg and the frame_pacing_rate_meter_unit RTL.
`timescale 1ns / 1ps

module frame_pacing_rate_meter_unit_tb;
	import frpm_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 5000;

	typedef struct {
		logic              go;
		logic [TICK_W-1:0] wait_t;
		logic [CNT_W-1:0]  logic_r;
		logic [CNT_W-1:0]  render_r;
		logic [CNT_W-1:0]  loop_r;
	} pacing_verdict_t;

	// Pacing state mirror and queue of verdicts awaiting the block's results
	class pacing_scoreboard;
		logic [CFG_W-1:0]  sec_len;
		logic [CFG_W-1:0]  frame_len;
		logic [TIME_W-1:0] frame_base;
		logic [TIME_W-1:0] second_base;
		logic [TIME_W-1:0] overrun;
		logic [CNT_W-1:0]  logic_cnt, render_cnt, loop_cnt;
		logic [CNT_W-1:0]  logic_snap, render_snap, loop_snap;
		logic              sec_flag;
		pacing_verdict_t   pending_verdicts[$];
		int mismatches, requests, rollovers, skips, early_renders;

		function new();
			sec_len     = TPS_RESET;
			frame_len   = FT_RESET;
			frame_base  = '0;
			second_base = '0;
			overrun     = '0;
			logic_cnt   = '0;
			render_cnt  = '0;
			loop_cnt    = '0;
			logic_snap  = '0;
			render_snap = '0;
			loop_snap   = '0;
			sec_flag    = 1'b0;
			mismatches  = 0;
			requests    = 0;
			rollovers   = 0;
			skips       = 0;
			early_renders = 0;
		endfunction

		function void set_lengths(logic [CFG_W-1:0] tps, logic [CFG_W-1:0] ft);
			sec_len   = tps;
			frame_len = ft;
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == CNT_MAX) ? v : v + 1'b1;
		endfunction

		// Realign the second base when a full second has passed
		function bit roll_second(logic [TIME_W-1:0] t_now);
			logic [TIME_W-1:0] d;
			logic [TIME_W-1:0] len;
			d   = t_now - second_base;
			len = {32'b0, sec_len};
			if (d[TIME_W-1] || d < len)
				return 1'b0;
			if (sec_len == '0)
				second_base = t_now;
			else
				second_base = t_now - (d % len);
			sec_flag = 1'b1;
			rollovers++;
			return 1'b1;
		endfunction

		function void note_request(cmd_t c, logic [TICK_W-1:0] tick);
			logic [TIME_W-1:0] t_now, d, ft64, ex, sum, w;
			pacing_verdict_t v;
			t_now = {1'b0, tick};
			ft64  = {32'b0, frame_len};
			d     = t_now - frame_base;
			v.go     = 1'b0;
			v.wait_t = '0;
			requests++;
			case (c)
				CMD_LOGIC: begin
					if (roll_second(t_now)) begin
						logic_snap = logic_cnt;
						logic_cnt  = '0;
						loop_snap  = loop_cnt;
						loop_cnt   = '0;
					end
					loop_cnt = bump(loop_cnt);
					if (!d[TIME_W-1] && d >= ft64) begin
						logic_cnt  = bump(logic_cnt);
						frame_base = frame_base + ft64;
						v.go = 1'b1;
					end
				end
				CMD_RENDER: begin
					if (roll_second(t_now)) begin
						logic_snap  = logic_cnt;
						logic_cnt   = '0;
						render_snap = render_cnt;
						render_cnt  = '0;
					end
					logic_cnt  = bump(logic_cnt);
					frame_base = frame_base + ft64;
					if (overrun > ft64) begin
						// pay back accumulated overrun by skipping this render
						overrun = overrun - ft64;
						skips++;
					end else begin
						if (!d[TIME_W-1] && d >= ft64) begin
							ex  = d - ft64;
							sum = overrun + ex;
							overrun = (sum < overrun) ? '1 : sum;
						end else begin
							w = d[TIME_W-1] ? ft64 + (-d) : ft64 - d;
							v.wait_t = (w > {1'b0, MAX_TICK}) ? MAX_TICK : w[TICK_W-1:0];
							early_renders++;
						end
						render_cnt = bump(render_cnt);
						v.go = 1'b1;
					end
				end
				CMD_FLAG: begin
					v.go     = sec_flag;
					sec_flag = 1'b0;
				end
				default: begin
					frame_base  = t_now;
					second_base = t_now;
				end
			endcase
			v.logic_r  = logic_snap;
			v.render_r = render_snap;
			v.loop_r   = loop_snap;
			pending_verdicts.push_back(v);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_result(logic g, logic [TICK_W-1:0] wt, logic [CNT_W-1:0] lr,
				logic [CNT_W-1:0] rr, logic [CNT_W-1:0] pr);
			pacing_verdict_t v;
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with no request pending");
				return;
			end
			v = pending_verdicts.pop_front();
			if (g !== v.go)
				report_mismatch($sformatf("go got %b want %b", g, v.go));
			if (wt !== v.wait_t)
				report_mismatch($sformatf("wait_ticks got %0d want %0d", wt, v.wait_t));
			if (lr !== v.logic_r)
				report_mismatch($sformatf("logic_rate got %0d want %0d", lr, v.logic_r));
			if (rr !== v.render_r)
				report_mismatch($sformatf("render_rate got %0d want %0d", rr, v.render_r));
			if (pr !== v.loop_r)
				report_mismatch($sformatf("loop_rate got %0d want %0d", pr, v.loop_r));
		endtask
	endclass

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic              cfg_index  = REG_TPS;
	logic [CFG_W-1:0]  cfg_data   = '0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd        = CMD_LOGIC;
	logic [TICK_W-1:0] now_ticks  = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic              go;
	logic [TICK_W-1:0] wait_ticks;
	logic [CNT_W-1:0]  logic_rate;
	logic [CNT_W-1:0]  render_rate;
	logic [CNT_W-1:0]  loop_rate;

	pacing_scoreboard  sb;
	int                snd_idle_pct = 0;
	int                rcv_idle_pct = 0;
	logic              hold_toggle  = 1'b0;
	logic              hold_seen    = 1'b0;
	int                hold_left    = 0;
	int                quiet_cycles = 0;
	logic [TICK_W-1:0] cur_tick     = '0;

	frame_pacing_rate_meter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.now_ticks   (now_ticks),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.go          (go),
		.wait_ticks  (wait_ticks),
		.logic_rate  (logic_rate),
		.render_rate (render_rate),
		.loop_rate   (loop_rate)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	// Monitor both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(cmd_t'(cmd), now_ticks);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(go, wait_ticks, logic_rate, render_rate, loop_rate);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("[frame_pacing_rate_meter_unit] ERROR");
			$finish;
		end
	end

	// Offer one request, idling first at random, and hold it until accepted
	task send_req(cmd_t c, logic [TICK_W-1:0] tick);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		now_ticks <= tick;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drain every pending result, then let the pipeline go quiet
	task settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both lengths; call only while the block is idle
	task write_lengths(logic [CFG_W-1:0] tps, logic [CFG_W-1:0] ft);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TPS;
		cfg_data  <= tps;
		@(posedge clk);
		cfg_index <= REG_FT;
		cfg_data  <= ft;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_lengths(tps, ft);
	endtask

	// Advance the tick count: mostly frame-sized steps, sometimes seconds,
	// backward steps, wild values and values near the top of the range
	function automatic logic [TICK_W-1:0] next_tick(logic [TICK_W-1:0] cur);
		logic [TIME_W-1:0] ft64, tps64, step;
		int unsigned r;
		ft64  = {32'b0, sb.frame_len};
		tps64 = {32'b0, sb.sec_len};
		r     = $urandom_range(0, 99);
		if (r < 70) begin
			step = ft64 * $urandom_range(0, 200) / 100;
			return cur + step[TICK_W-1:0];
		end
		if (r < 80) begin
			step = tps64 * $urandom_range(1, 3);
			return cur + step[TICK_W-1:0];
		end
		if (r < 88)
			return cur - $urandom_range(0, sb.frame_len);
		if (r < 94)
			return TICK_W'({$urandom, $urandom});
		return MAX_TICK - $urandom_range(0, 1000);
	endfunction

	// Optionally run a start request, then a mix of frame checks, renders, flag reads and starts
	task run_random(int n, bit with_start);
		int unsigned r;
		cmd_t c;
		if (with_start) begin
			cur_tick = TICK_W'({$urandom_range(0, 3), $urandom});
			send_req(CMD_START, cur_tick);
		end
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				c = CMD_LOGIC;
			else if (r < 75)
				c = CMD_RENDER;
			else if (r < 88)
				c = CMD_FLAG;
			else
				c = CMD_START;
			cur_tick = next_tick(cur_tick);
			send_req(c, cur_tick);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] tps;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default lengths straight out of reset
		send_req(CMD_FLAG, 63'd0);
		send_req(CMD_LOGIC, 63'd0);
		send_req(CMD_LOGIC, 63'd166666);
		send_req(CMD_RENDER, 63'd10000000);
		send_req(CMD_FLAG, 63'd0);
		send_req(CMD_FLAG, 63'd0);
		settle();

		// Small lengths: due and not due, early and late renders, skips
		write_lengths(32'd100, 32'd10);
		send_req(CMD_START, 63'd1000);
		send_req(CMD_LOGIC, 63'd1005);
		send_req(CMD_LOGIC, 63'd1010);
		send_req(CMD_RENDER, 63'd1012);
		// render with the frame base ahead of now
		send_req(CMD_RENDER, 63'd1000);
		send_req(CMD_START, MAX_TICK);
		send_req(CMD_LOGIC, 63'd0);
		// huge wait saturates
		send_req(CMD_RENDER, 63'd0);
		send_req(CMD_RENDER, MAX_TICK);
		send_req(CMD_START, 63'd1000);
		send_req(CMD_RENDER, 63'd1100);
		send_req(CMD_RENDER, 63'd1101);
		send_req(CMD_FLAG, 63'd0);
		send_req(CMD_FLAG, 63'd0);
		send_req(CMD_LOGIC, 63'd1300);
		settle();

		// Sender busy, receiver mostly stalled
		snd_idle_pct = 8;
		rcv_idle_pct <= 79;
		tps = $urandom_range(40, 400);
		write_lengths(tps, $urandom_range(1, tps / 4));
		run_random(100, 1'b1);
		settle();

		// Sender mostly idle, largest lengths
		snd_idle_pct = 79;
		rcv_idle_pct <= 8;
		write_lengths('1, '1);
		run_random(100, 1'b1);
		settle();

		// No idling, smallest lengths
		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		write_lengths(32'd1, 32'd1);
		run_random(100, 1'b1);
		settle();

		// No idling, wide lengths, with a long receiver hold-off
		tps = $urandom_range(1000, 100000);
		write_lengths(tps, $urandom_range(tps / 50, tps / 5));
		run_random(20, 1'b1);
		hold_toggle <= ~hold_toggle;
		run_random(40, 1'b0);
		run_random(40, 1'b0);
		settle();

		$display("covered %0d requests: %0d second rollovers, %0d skipped and %0d early renders",
			sb.requests, sb.rollovers, sb.skips, sb.early_renders);
		$display("length settings: reset, small, random, all ones and one; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
			$display("[frame_pacing_rate_meter_unit] OK");
		else
			$display("[frame_pacing_rate_meter_unit] ERROR");
		$finish;
	end

endmodule
